// ----- hdl/mwv_pkg.sv -----
// mwv_pkg: shared types and constants of the mask window validity check unit
// used by the front classifier, the command queue, the back end and the top level
// no dependencies
package mwv_pkg;

   // query position format
   localparam int POS_W  = 24;
   localparam int FRAC_W = 8;
   // pixel center index, wide enough for any rounded position plus edge offsets
   localparam int CT_W   = 18;
   // row and column fields of a command, sized for the largest storage
   localparam int IDX_W  = 12;
   // widest window side in pixels
   localparam int WIN_W  = 4;
   // command queue
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = 1;

   localparam logic signed [CT_W-1:0] C_ZERO = 0;
   localparam logic signed [CT_W-1:0] C_ONE  = 1;
   localparam logic signed [CT_W-1:0] C_TWO  = 2;

   // column window masks
   localparam logic [WIN_W-1:0] NC_ONE  = 4'b0001;
   localparam logic [WIN_W-1:0] NC_TWO  = 4'b0011;
   localparam logic [WIN_W-1:0] NC_FOUR = 4'b1111;

   // rows in the window, minus one
   localparam logic [1:0] NR_ONE  = 2'd0;
   localparam logic [1:0] NR_TWO  = 2'd1;
   localparam logic [1:0] NR_FOUR = 2'd3;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // register indexes of the csr channel
   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_ROWS = 2'd1;
   localparam logic [1:0] REG_COLS = 2'd2;

   // result status codes
   localparam logic [1:0] ST_QUERY_DONE = 2'd0;
   localparam logic [1:0] ST_OUTSIDE    = 2'd1;
   localparam logic [1:0] ST_NOT_IMPL   = 2'd2;
   localparam logic [1:0] ST_WRITE_DONE = 2'd3;

   typedef enum logic [1:0] {
      MODE_NEAREST = 2'd0,
      MODE_LINEAR  = 2'd1,
      MODE_CUBIC   = 2'd2,
      MODE_LANCZOS = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_RESULT = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_kind_type;

   // one classified item on its way from front to back
   typedef struct packed {
      cmd_kind_type     kind;
      logic             ok;
      logic [1:0]       status;
      logic             wr_bit;
      logic [IDX_W-1:0] r0;
      logic [IDX_W-1:0] c0;
      logic [1:0]       nr_m1;
      logic [WIN_W-1:0] nc_mask;
   } cmd_type;

   // trunc((p + 0.5)) toward zero for a position with FRAC_W fraction bits
   function automatic logic signed [CT_W-1:0] centre_of(input logic signed [POS_W-1:0] p);
      logic signed [POS_W+1:0] s;
      logic signed [POS_W+1:0] adj;
      s   = (POS_W+2)'(p) + (POS_W+2)'(signed'(1 << (FRAC_W - 1)));
      adj = s + (s[POS_W+1] ? (POS_W+2)'(signed'((1 << FRAC_W) - 1)) : '0);
      return adj[POS_W+1:FRAC_W];
   endfunction

endpackage

// ----- hdl/mwv_front.sv -----
// mwv_front: input stage and classifier of the mask window validity check unit
// rounds the query position, picks the window and pushes a command to the queue
// depends on mwv_pkg
module mwv_front import mwv_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_func,
   input  logic [5:0]              req_wr_row,
   input  logic [5:0]              req_wr_col,
   input  logic                    req_wr_bit,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  mode_type                mode,
   input  logic [6:0]              num_rows,
   input  logic [6:0]              num_cols,
   input  logic                    q_full,
   output logic                    push,
   output cmd_type                 cmd
);

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_func_ff;
   logic [5:0]              s1_wr_row_ff;
   logic [5:0]              s1_wr_col_ff;
   logic                    s1_wr_bit_ff;
   logic signed [POS_W-1:0] s1_pos_x_ff;
   logic signed [POS_W-1:0] s1_pos_y_ff;
   logic                    accept;

   logic signed [CT_W-1:0] ci, cj, li, lj, rows_e, cols_e;
   logic                   near_in, lin_in, cub_edge, wr_in_range;

   assign busy   = s1_valid_ff & q_full;
   assign accept = start & ~busy;
   assign push   = s1_valid_ff & ~q_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff   <= req_func;
         s1_wr_row_ff <= req_wr_row;
         s1_wr_col_ff <= req_wr_col;
         s1_wr_bit_ff <= req_wr_bit;
         s1_pos_x_ff  <= req_pos_x;
         s1_pos_y_ff  <= req_pos_y;
      end
   end

   // extents in use, clipped to the storage
   always_comb begin
      if (32'(num_rows) > MAX_ROWS) begin
         rows_e = CT_W'(MAX_ROWS);
      end else begin
         rows_e = CT_W'(num_rows);
      end
      if (32'(num_cols) > MAX_COLS) begin
         cols_e = CT_W'(MAX_COLS);
      end else begin
         cols_e = CT_W'(num_cols);
      end
   end

   assign ci = centre_of(s1_pos_x_ff);
   assign cj = centre_of(s1_pos_y_ff);

   // linear window moves back by one on the last row or column
   assign li = (ci == rows_e - C_ONE) ? ci - C_ONE : ci;
   assign lj = (cj == cols_e - C_ONE) ? cj - C_ONE : cj;

   assign near_in  = (ci >= C_ZERO) && (ci <= rows_e - C_ONE) &&
                     (cj >= C_ZERO) && (cj <= cols_e - C_ONE);
   assign lin_in   = (li >= C_ZERO) && (li + C_ONE <= rows_e - C_ONE) &&
                     (lj >= C_ZERO) && (lj + C_ONE <= cols_e - C_ONE);
   assign cub_edge = (ci <= C_ZERO) || (ci >= rows_e - C_TWO) ||
                     (cj <= C_ZERO) || (cj >= cols_e - C_TWO);

   assign wr_in_range = (32'(s1_wr_row_ff) < MAX_ROWS) && (32'(s1_wr_col_ff) < MAX_COLS);

   always_comb begin
      cmd.kind    = CMD_RESULT;
      cmd.ok      = 1'b0;
      cmd.status  = ST_OUTSIDE;
      cmd.wr_bit  = s1_wr_bit_ff;
      cmd.r0      = '0;
      cmd.c0      = '0;
      cmd.nr_m1   = NR_ONE;
      cmd.nc_mask = NC_ONE;
      if (s1_func_ff == FUNC_WRITE) begin
         cmd.status = ST_WRITE_DONE;
         cmd.r0     = IDX_W'(s1_wr_row_ff);
         cmd.c0     = IDX_W'(s1_wr_col_ff);
         if (wr_in_range) begin
            cmd.kind = CMD_WRITE;
            cmd.ok   = 1'b1;
         end
      end else begin
         case (mode)
            MODE_NEAREST: begin
               if (near_in) begin
                  cmd.kind = CMD_QUERY;
                  cmd.r0   = IDX_W'(ci);
                  cmd.c0   = IDX_W'(cj);
               end
            end
            MODE_LINEAR: begin
               if (lin_in) begin
                  cmd.kind    = CMD_QUERY;
                  cmd.r0      = IDX_W'(li);
                  cmd.c0      = IDX_W'(lj);
                  cmd.nr_m1   = NR_TWO;
                  cmd.nc_mask = NC_TWO;
               end
            end
            MODE_CUBIC: begin
               if (!cub_edge) begin
                  cmd.kind    = CMD_QUERY;
                  cmd.r0      = IDX_W'(ci - C_ONE);
                  cmd.c0      = IDX_W'(cj - C_ONE);
                  cmd.nr_m1   = NR_FOUR;
                  cmd.nc_mask = NC_FOUR;
               end else if (lin_in) begin
                  cmd.kind    = CMD_QUERY;
                  cmd.r0      = IDX_W'(li);
                  cmd.c0      = IDX_W'(lj);
                  cmd.nr_m1   = NR_TWO;
                  cmd.nc_mask = NC_TWO;
               end
            end
            default: begin
               cmd.status = ST_NOT_IMPL;
            end
         endcase
         if (cmd.kind == CMD_QUERY) begin
            cmd.ok     = 1'b1;
            cmd.status = ST_QUERY_DONE;
         end
      end
   end

endmodule

// ----- hdl/mwv_cmd_fifo.sv -----
// mwv_cmd_fifo: two-entry command queue between front and back
// depends on mwv_pkg
module mwv_cmd_fifo import mwv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type         q_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;

   assign full  = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/mwv_back.sv -----
// mwv_back: back end of the mask window validity check unit
// holds the row-wide mask memory, walks the window rows and drives the result
// depends on mwv_pkg
module mwv_back import mwv_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   output logic       rsp_ok,
   output logic       rsp_mask_good,
   output logic [1:0] rsp_status
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_READ = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           acc_ff, acc_in;
   logic           rd_pend_ff, rd_pend_in;
   logic           rd_last_ff, rd_last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic           rsp_good_ff, rsp_good_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;

   logic [MAX_COLS-1:0]       mem [MAX_ROWS];
   logic [MAX_COLS-1:0]       rd_data_ff;
   logic [MAX_COLS+WIN_W-1:0] rd_ext;
   logic [WIN_W-1:0]          win_bits;
   logic                      win_ok;
   logic                      mem_we, mem_re;
   logic [RW-1:0]             raddr;

   assign rd_ext   = {{WIN_W{1'b0}}, rd_data_ff} >> cur_ff.c0[CW-1:0];
   assign win_bits = rd_ext[WIN_W-1:0];
   assign win_ok   = &(win_bits | ~cur_ff.nc_mask);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      rd_pend_in    = 1'b0;
      rd_last_in    = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_ok_in     = rsp_ok_ff;
      rsp_good_in   = rsp_good_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      raddr         = cur_ff.r0[RW-1:0] + RW'(cnt_ff);

      // fold in the row read last cycle
      if (rd_pend_ff) begin
         if (rd_last_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_ok_in     = 1'b1;
            rsp_good_in   = acc_ff & win_ok;
            rsp_status_in = ST_QUERY_DONE;
         end else begin
            acc_in = acc_ff & win_ok;
         end
      end

      case (state_ff)
         B_IDLE: begin
            // a finishing query owns the result register this cycle
            if (!empty && (!rd_last_ff || head.kind == CMD_QUERY)) begin
               pop = 1'b1;
               case (head.kind)
                  CMD_WRITE: begin
                     mem_we        = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_ok_in     = 1'b1;
                     rsp_good_in   = 1'b0;
                     rsp_status_in = ST_WRITE_DONE;
                  end
                  CMD_QUERY: begin
                     cur_in     = head;
                     raddr      = head.r0[RW-1:0];
                     mem_re     = 1'b1;
                     cnt_in     = 2'd1;
                     acc_in     = 1'b1;
                     rd_pend_in = 1'b1;
                     rd_last_in = (head.nr_m1 == NR_ONE);
                     if (head.nr_m1 != NR_ONE) begin
                        state_in = B_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_ok_in     = head.ok;
                     rsp_good_in   = 1'b0;
                     rsp_status_in = head.status;
                  end
               endcase
            end
         end
         B_READ: begin
            mem_re     = 1'b1;
            rd_pend_in = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == cur_ff.nr_m1) begin
               rd_last_in = 1'b1;
               state_in   = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_good_ff   <= rsp_good_in;
      rsp_status_ff <= rsp_status_in;
   end

   // mask memory, one word per row, single bit write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[head.r0[RW-1:0]][head.c0[CW-1:0]] <= head.wr_bit;
      end
      if (mem_re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_mask_good = rsp_good_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- hdl/mask_window_validity_check_unit.sv -----
// mask_window_validity_check_unit: top level, csr registers and assertions
// instantiates mwv_front, mwv_cmd_fifo and mwv_back; depends on mwv_pkg
//
// Usage
//   Items enter on the req_ ports: an item is taken at a clock edge with start high and
//   busy low. req_func selects a mask bit write (req_wr_row, req_wr_col, req_wr_bit) or
//   a validity query at (req_pos_x, req_pos_y), signed with 8 fraction bits.
//   Each item gives one result on rsp_ok, rsp_mask_good, rsp_status, shown for one
//   cycle with rsp_valid high. The receiver cannot stall; results are never held.
//   Registers (mode, rows, cols) are written over csr_valid/csr_ready with csr_index
//   and csr_wdata; the user must write them only while the unit is idle, as the block
//   does not enforce it; csr_ready is always high. The back end takes one item per
//   cycle for writes and nearest queries, but a write waits while a finishing query
//   owns the result register; linear and cubic queries hold it in its read state until
//   every window row is read. It reads one mask row per cycle from a single-port
//   row-wide memory. A two-entry queue separates the classifier from the back end,
//   and busy rises when both are full.
//   Reset clears control state and loads mode linear, 64 rows, 64 columns. The mask
//   memory is not cleared: every bit that a query covers must have been written.
module mask_window_validity_check_unit import mwv_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_func,
   input  logic [5:0]              req_wr_row,
   input  logic [5:0]              req_wr_col,
   input  logic                    req_wr_bit,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   output logic                    rsp_valid,
   output logic                    rsp_ok,
   output logic                    rsp_mask_good,
   output logic [1:0]              rsp_status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [6:0]              csr_wdata
);

   mode_type   mode_ff, mode_in;
   logic [6:0] num_rows_ff, num_rows_in;
   logic [6:0] num_cols_ff, num_cols_in;

   logic    push, pop, q_full, q_empty;
   cmd_type push_cmd, head;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE: mode_in     = mode_type'(csr_wdata[1:0]);
            REG_ROWS: num_rows_in = csr_wdata;
            REG_COLS: num_cols_in = csr_wdata;
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_LINEAR;
         num_rows_ff <= 7'd64;
         num_cols_ff <= 7'd64;
      end else begin
         mode_ff     <= mode_in;
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   mwv_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_wr_row (req_wr_row),
      .req_wr_col (req_wr_col),
      .req_wr_bit (req_wr_bit),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .mode       (mode_ff),
      .num_rows   (num_rows_ff),
      .num_cols   (num_cols_ff),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   mwv_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   mwv_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (q_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ok        (rsp_ok),
      .rsp_mask_good (rsp_mask_good),
      .rsp_status    (rsp_status)
   );

`ifndef SYNTHESIS
   // the queue never takes a transfer while full nor gives one while empty
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_empty))
      else $error("command popped from an empty queue");

   // outside-grid and lanczos results never report a good window
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OUTSIDE || rsp_status == ST_NOT_IMPL)
      |-> !rsp_ok && !rsp_mask_good)
      else $error("failed query reported ok or good");

   // a finished query always lay inside the grid
   a_query_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_QUERY_DONE |-> rsp_ok)
      else $error("query done without ok");
`endif

endmodule
